// File: src/nnds_pkg.sv
// Shared types and constants of the nearest-neighbor downscaler.
package nnds_pkg;

    localparam int PIXEL_BITS     = 8;
    localparam int SIZE_BITS      = 13;
    localparam int POS_BITS       = 29;
    localparam int FRAC_BITS      = 16;
    localparam int POS_INT_BITS   = POS_BITS - FRAC_BITS;
    localparam int CFG_INDEX_BITS = 3;
    localparam int CFG_DATA_BITS  = 29;
    localparam int QUEUE_DEPTH    = 2;

    localparam logic [POS_BITS-1:0] STEP_ONE = POS_BITS'(65536);
    localparam logic [POS_BITS-1:0] POS_MAX  = {POS_BITS{1'b1}};

    typedef enum logic [CFG_INDEX_BITS-1:0] {
        CFG_SOURCE_COLUMNS = 3'd0,
        CFG_SOURCE_ROWS    = 3'd1,
        CFG_OUTPUT_COLUMNS = 3'd2,
        CFG_OUTPUT_ROWS    = 3'd3,
        CFG_COLUMN_STEP    = 3'd4,
        CFG_ROW_STEP       = 3'd5
    } cfg_index_t;

    typedef struct packed {
        logic [PIXEL_BITS-1:0] pixel;
        logic                  row_end;
        logic                  frame_end;
    } item_t;

    typedef struct packed {
        logic valid;
        logic full;
    } q_status_t;

endpackage

// File: src/nearest_neighbor_downscaler_top.sv
// A picked pixel is written into the queue and then loaded into the output register before
// it is presented on the master side.
// Throughput: one source pixel per cycle; the input stalls only when the
// two-entry queue is full.
// Reset: sizes 1x1, unit steps, counters cleared, queue and output empty.
// Top level of the nearest-neighbor downscaler.
module nearest_neighbor_downscaler_top #(
    parameter int MAX_DIMENSION = 4096
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [nnds_pkg::CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [nnds_pkg::CFG_DATA_BITS-1:0]  cfg_data,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [nnds_pkg::PIXEL_BITS-1:0]     s_tdata,   // [7:0] pixel_in
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [nnds_pkg::PIXEL_BITS-1:0]     m_tdata,   // [7:0] pixel_out
    output logic                                m_tlast,   // row_end
    output logic                                m_tuser    // [0] frame_end
);
    import nnds_pkg::*;

    q_status_t q_status;
    item_t     push_item, q_item;
    logic      push, pop;

    nnds_front #(
        .MAX_DIMENSION(MAX_DIMENSION)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .q_status  (q_status),
        .push      (push),
        .push_item (push_item)
    );

    nnds_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (push_item),
        .pop       (pop),
        .q_status  (q_status),
        .q_item    (q_item)
    );

    nnds_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_status (q_status),
        .q_item   (q_item),
        .pop      (pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

    a_frame_end_on_row_end: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser |-> m_tlast)
        else $error("frame end without row end");

    a_full_means_output_held: assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> m_tvalid)
        else $error("input stalled while output register empty");

    a_pop_only_with_data: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> q_status.valid)
        else $error("queue popped while empty");

endmodule

// File: src/nnds_front.sv
// Front end: configuration, source counters and pick classification.
module nnds_front #(
    parameter int MAX_DIMENSION = 4096
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_we,
    input  logic [nnds_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
    input  logic [nnds_pkg::CFG_DATA_BITS-1:0]   cfg_data,
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    input  logic [nnds_pkg::PIXEL_BITS-1:0]      s_tdata,
    input  nnds_pkg::q_status_t                  q_status,
    output logic                                 push,
    output nnds_pkg::item_t                      push_item
);
    import nnds_pkg::*;

    localparam int DW = $clog2(MAX_DIMENSION + 1);
    localparam int CW = $clog2(MAX_DIMENSION);
    localparam int SW = (DW > SIZE_BITS) ? DW : SIZE_BITS;
    localparam int EW = (CW > POS_INT_BITS) ? CW : POS_INT_BITS;
    localparam logic [SW-1:0] MAX_SIZE = SW'(MAX_DIMENSION);

    function automatic logic [DW-1:0] clamp_size(input logic [SIZE_BITS-1:0] v);
        logic [SW-1:0] w;
        begin
            w = SW'(v);
            if (w == '0)
                return DW'(1);
            if (w > MAX_SIZE)
                return DW'(MAX_DIMENSION);
            return DW'(w);
        end
    endfunction

    function automatic logic [POS_BITS-1:0] clamp_step(input logic [POS_BITS-1:0] v);
        return (v < STEP_ONE) ? STEP_ONE : v;
    endfunction

    function automatic logic [POS_BITS-1:0] sat_add(input logic [POS_BITS-1:0] a,
                                                    input logic [POS_BITS-1:0] b);
        logic [POS_BITS:0] s;
        begin
            s = {1'b0, a} + {1'b0, b};
            return s[POS_BITS] ? POS_MAX : s[POS_BITS-1:0];
        end
    endfunction

    // sizes and steps are stored already clamped
    logic [DW-1:0]       src_cols_reg, src_rows_reg, out_cols_reg, out_rows_reg;
    logic [POS_BITS-1:0] col_step_reg, row_step_reg;

    logic [CW-1:0]       src_col_reg, src_col_next, src_row_reg, src_row_next;
    logic [POS_BITS-1:0] col_pos_reg, col_pos_next, row_pos_reg, row_pos_next;
    logic [DW-1:0]       out_col_reg, out_col_next, out_row_reg, out_row_next;

    logic          accept, row_hit, col_hit, row_last, frame_last, re, fe;
    logic [DW-1:0] col_inc, row_inc;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            src_cols_reg <= DW'(1);
            src_rows_reg <= DW'(1);
            out_cols_reg <= DW'(1);
            out_rows_reg <= DW'(1);
            col_step_reg <= STEP_ONE;
            row_step_reg <= STEP_ONE;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_SOURCE_COLUMNS: src_cols_reg <= clamp_size(cfg_data[SIZE_BITS-1:0]);
                CFG_SOURCE_ROWS:    src_rows_reg <= clamp_size(cfg_data[SIZE_BITS-1:0]);
                CFG_OUTPUT_COLUMNS: out_cols_reg <= clamp_size(cfg_data[SIZE_BITS-1:0]);
                CFG_OUTPUT_ROWS:    out_rows_reg <= clamp_size(cfg_data[SIZE_BITS-1:0]);
                CFG_COLUMN_STEP:    col_step_reg <= clamp_step(cfg_data[POS_BITS-1:0]);
                CFG_ROW_STEP:       row_step_reg <= clamp_step(cfg_data[POS_BITS-1:0]);
                default: ;
            endcase
        end
    end

    assign s_tready = !q_status.full;
    assign accept   = s_tvalid && s_tready;

    assign row_hit  = (EW'(src_row_reg) == EW'(row_pos_reg[POS_BITS-1:FRAC_BITS]))
                      && (out_row_reg < out_rows_reg);
    assign col_hit  = row_hit
                      && (EW'(src_col_reg) == EW'(col_pos_reg[POS_BITS-1:FRAC_BITS]))
                      && (out_col_reg < out_cols_reg);
    assign col_inc  = out_col_reg + DW'(1);
    assign row_inc  = out_row_reg + DW'(1);
    assign re       = (col_inc == out_cols_reg);
    assign fe       = re && (row_inc == out_rows_reg);
    assign row_last   = (DW'(src_col_reg) + DW'(1)) >= src_cols_reg;
    assign frame_last = (DW'(src_row_reg) + DW'(1)) >= src_rows_reg;

    always_comb
    begin
        src_col_next = src_col_reg;
        src_row_next = src_row_reg;
        col_pos_next = col_pos_reg;
        row_pos_next = row_pos_reg;
        out_col_next = out_col_reg;
        out_row_next = out_row_reg;
        if (accept)
        begin
            if (col_hit)
            begin
                out_col_next = col_inc;
                col_pos_next = sat_add(col_pos_reg, col_step_reg);
            end
            if (row_last)
            begin
                src_col_next = '0;
                col_pos_next = '0;
                out_col_next = '0;
                if (row_hit)
                begin
                    out_row_next = row_inc;
                    row_pos_next = sat_add(row_pos_reg, row_step_reg);
                end
                if (frame_last)
                begin
                    src_row_next = '0;
                    row_pos_next = '0;
                    out_row_next = '0;
                end
                else
                begin
                    src_row_next = src_row_reg + CW'(1);
                end
            end
            else
            begin
                src_col_next = src_col_reg + CW'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            src_col_reg <= '0;
            src_row_reg <= '0;
            col_pos_reg <= '0;
            row_pos_reg <= '0;
            out_col_reg <= '0;
            out_row_reg <= '0;
        end
        else
        begin
            src_col_reg <= src_col_next;
            src_row_reg <= src_row_next;
            col_pos_reg <= col_pos_next;
            row_pos_reg <= row_pos_next;
            out_col_reg <= out_col_next;
            out_row_reg <= out_row_next;
        end
    end

    assign push                = accept && col_hit;
    assign push_item.pixel     = s_tdata;
    assign push_item.row_end   = re;
    assign push_item.frame_end = fe;

endmodule

// File: src/nnds_queue.sv
// Short queue of picked pixels between front and back.
module nnds_queue (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  nnds_pkg::item_t     push_item,
    input  logic                pop,
    output nnds_pkg::q_status_t q_status,
    output nnds_pkg::item_t     q_item
);
    import nnds_pkg::*;

    localparam int QAW = $clog2(QUEUE_DEPTH);

    item_t          slot_reg [QUEUE_DEPTH];
    logic [QAW-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [QAW:0]   count_reg, count_next;

    always_ff @(posedge clk)
    begin
        if (push)
            slot_reg[wr_ptr_reg] <= push_item;
    end

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
            count_next = count_reg + (QAW+1)'(1);
        else if (pop && !push)
            count_next = count_reg - (QAW+1)'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= wr_ptr_reg + QAW'(1);
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + QAW'(1);
            count_reg <= count_next;
        end
    end

    assign q_status.valid = (count_reg != '0);
    assign q_status.full  = (count_reg == (QAW+1)'(QUEUE_DEPTH));
    assign q_item         = slot_reg[rd_ptr_reg];

endmodule

// File: src/nnds_back.sv
// Back end: output register driving the master stream.
module nnds_back (
    input  logic                            clk,
    input  logic                            rst_n,
    input  nnds_pkg::q_status_t             q_status,
    input  nnds_pkg::item_t                 q_item,
    output logic                            pop,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [nnds_pkg::PIXEL_BITS-1:0] m_tdata,
    output logic                            m_tlast,
    output logic                            m_tuser
);
    import nnds_pkg::*;

    logic  valid_reg;
    item_t item_reg;

    assign pop = q_status.valid && (!valid_reg || m_tready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (!valid_reg || m_tready)
            valid_reg <= q_status.valid;
    end

    always_ff @(posedge clk)
    begin
        if (pop)
            item_reg <= q_item;
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = item_reg.pixel;
    assign m_tlast  = item_reg.row_end;
    assign m_tuser  = item_reg.frame_end;

endmodule

// File: tb/tb.sv
// Self-checking testbench for the nearest-neighbor image downscaler.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import nnds_pkg::*;

    localparam int MAX_DIM      = 4096;
    localparam int DRAIN_CYCLES = 8;
    localparam int RANDOM_ITEMS = 850;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_UNUSED_INDEX = 3'd7;

    logic                      clk = 1'b0;
    logic                      rst_n = 1'b0;
    logic                      cfg_we = 1'b0;
    logic [CFG_INDEX_BITS-1:0] cfg_index = '0;
    logic [CFG_DATA_BITS-1:0]  cfg_data = '0;
    logic                      s_tvalid = 1'b0;
    logic                      s_tready;
    logic [PIXEL_BITS-1:0]     s_tdata = '0;
    logic                      m_tvalid;
    logic                      m_tready = 1'b0;
    logic [PIXEL_BITS-1:0]     m_tdata;   // [7:0] pixel_out
    logic                      m_tlast;   // row_end
    logic                      m_tuser;   // [0] frame_end

    int send_idle_pct   = 0;
    int ready_stall_pct = 0;
    int fail_count      = 0;

    // shadow registers
    logic [SIZE_BITS-1:0] cfg_src_cols = 13'd1;
    logic [SIZE_BITS-1:0] cfg_src_rows = 13'd1;
    logic [SIZE_BITS-1:0] cfg_out_cols = 13'd1;
    logic [SIZE_BITS-1:0] cfg_out_rows = 13'd1;
    logic [POS_BITS-1:0]  cfg_col_step = STEP_ONE;
    logic [POS_BITS-1:0]  cfg_row_step = STEP_ONE;

    // scaler state
    logic [SIZE_BITS-1:0] src_col = '0;
    logic [SIZE_BITS-1:0] src_row = '0;
    logic [POS_BITS-1:0]  pick_col_pos = '0;
    logic [POS_BITS-1:0]  pick_row_pos = '0;
    logic [SIZE_BITS-1:0] picks_in_row = '0;
    logic [SIZE_BITS-1:0] rows_picked = '0;

    item_t scaled_pixels[$];
    item_t want;

    always #2 clk = ~clk;

    nearest_neighbor_downscaler_top #(
        .MAX_DIMENSION(MAX_DIM)
    ) dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

    function automatic logic [SIZE_BITS-1:0] used_size(input logic [SIZE_BITS-1:0] v);
        if (v == '0)
            return 13'd1;
        if (v > MAX_DIM)
            return 13'(MAX_DIM);
        return v;
    endfunction

    function automatic logic [POS_BITS-1:0] used_step(input logic [POS_BITS-1:0] v);
        return (v < STEP_ONE) ? STEP_ONE : v;
    endfunction

    function automatic logic [POS_BITS-1:0] advance_pos(input logic [POS_BITS-1:0] pos,
                                                        input logic [POS_BITS-1:0] step);
        logic [POS_BITS:0] sum;
        sum = {1'b0, pos} + {1'b0, step};
        return (sum > {1'b0, POS_MAX}) ? POS_MAX : sum[POS_BITS-1:0];
    endfunction

    function automatic void clear_frame();
        src_col      = '0;
        src_row      = '0;
        pick_col_pos = '0;
        pick_row_pos = '0;
        picks_in_row = '0;
        rows_picked  = '0;
    endfunction

    function automatic void store_reg(input logic [CFG_INDEX_BITS-1:0] idx,
                                      input logic [CFG_DATA_BITS-1:0] value);
        case (idx)
            CFG_SOURCE_COLUMNS: cfg_src_cols = value[SIZE_BITS-1:0];
            CFG_SOURCE_ROWS:    cfg_src_rows = value[SIZE_BITS-1:0];
            CFG_OUTPUT_COLUMNS: cfg_out_cols = value[SIZE_BITS-1:0];
            CFG_OUTPUT_ROWS:    cfg_out_rows = value[SIZE_BITS-1:0];
            CFG_COLUMN_STEP:    cfg_col_step = value[POS_BITS-1:0];
            CFG_ROW_STEP:       cfg_row_step = value[POS_BITS-1:0];
            default: ;
        endcase
    endfunction

    function automatic void select_pixel(input logic [PIXEL_BITS-1:0] pix);
        logic [SIZE_BITS-1:0] sc;
        logic [SIZE_BITS-1:0] sr;
        logic [SIZE_BITS-1:0] oc;
        logic [SIZE_BITS-1:0] orows;
        logic                 on_row;
        logic                 at_row_end;
        item_t                pick;
        sc    = used_size(cfg_src_cols);
        sr    = used_size(cfg_src_rows);
        oc    = used_size(cfg_out_cols);
        orows = used_size(cfg_out_rows);
        on_row = (src_row == pick_row_pos[POS_BITS-1:FRAC_BITS]) && (rows_picked < orows);

        if (on_row && src_col == pick_col_pos[POS_BITS-1:FRAC_BITS] && picks_in_row < oc)
        begin
            picks_in_row   = picks_in_row + 13'd1;
            pick_col_pos   = advance_pos(pick_col_pos, used_step(cfg_col_step));
            at_row_end     = (picks_in_row == oc);
            pick.pixel     = pix;
            pick.row_end   = at_row_end;
            pick.frame_end = at_row_end && (rows_picked + 1 == orows);
            scaled_pixels.push_back(pick);
        end

        if (src_col + 1 >= sc)
        begin
            src_col      = '0;
            pick_col_pos = '0;
            picks_in_row = '0;
            if (on_row)
            begin
                rows_picked  = rows_picked + 13'd1;
                pick_row_pos = advance_pos(pick_row_pos, used_step(cfg_row_step));
            end
            if (src_row + 1 >= sr)
                clear_frame();
            else
                src_row = src_row + 13'd1;
        end
        else
        begin
            src_col = src_col + 13'd1;
        end
    endfunction

    function automatic int frame_pixels_left();
        int sc;
        int sr;
        int rows_left;
        int cols_left;
        sc = int'(used_size(cfg_src_cols));
        sr = int'(used_size(cfg_src_rows));
        rows_left = (int'(src_row) + 1 >= sr) ? 0 : sr - 1 - int'(src_row);
        cols_left = (int'(src_col) + 1 >= sc) ? 1 : sc - int'(src_col);
        return rows_left * sc + cols_left;
    endfunction

    // predictor and checker, both on the sampling edge
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (cfg_we)
                store_reg(cfg_index, cfg_data);
            if (s_tvalid && s_tready)
                select_pixel(s_tdata);
            if (m_tvalid && m_tready)
            begin
                if (scaled_pixels.size() == 0)
                begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("unexpected transaction: pixel %02h row_end %0b frame_end %0b",
                                 m_tdata, m_tlast, m_tuser);
                end
                else
                begin
                    want = scaled_pixels.pop_front();
                    if (m_tdata !== want.pixel || m_tlast !== want.row_end ||
                        m_tuser !== want.frame_end)
                    begin
                        fail_count++;
                        if (fail_count <= 10)
                            $display("pick mismatch: expected %02h/%0b/%0b, got %02h/%0b/%0b",
                                     want.pixel, want.row_end, want.frame_end,
                                     m_tdata, m_tlast, m_tuser);
                    end
                end
            end
        end
    end

    always @(negedge clk)
        m_tready <= ($urandom_range(99) >= ready_stall_pct);

    task automatic set_idling(input int send_pct, input int stall_pct);
        send_idle_pct   = send_pct;
        ready_stall_pct = stall_pct;
    endtask

    task automatic write_reg(input logic [CFG_INDEX_BITS-1:0] idx,
                             input logic [CFG_DATA_BITS-1:0] value);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(negedge clk);
        cfg_we    <= 1'b0;
    endtask

    task automatic set_geometry(input logic [CFG_DATA_BITS-1:0] sc,
                                input logic [CFG_DATA_BITS-1:0] sr,
                                input logic [CFG_DATA_BITS-1:0] oc,
                                input logic [CFG_DATA_BITS-1:0] orows,
                                input logic [CFG_DATA_BITS-1:0] col_step,
                                input logic [CFG_DATA_BITS-1:0] row_step);
        write_reg(CFG_SOURCE_COLUMNS, sc);
        write_reg(CFG_SOURCE_ROWS, sr);
        write_reg(CFG_OUTPUT_COLUMNS, oc);
        write_reg(CFG_OUTPUT_ROWS, orows);
        write_reg(CFG_COLUMN_STEP, col_step);
        write_reg(CFG_ROW_STEP, row_step);
    endtask

    task automatic send_pixel(input logic [PIXEL_BITS-1:0] pix);
        @(negedge clk);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= pix;
        do
            @(posedge clk);
        while (!s_tready);
    endtask

    task automatic send_pixels(input int count);
        repeat (count)
            send_pixel(PIXEL_BITS'($urandom_range(255)));
    endtask

    task automatic drain();
        @(negedge clk);
        s_tvalid <= 1'b0;
        while (scaled_pixels.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic finish_frame();
        send_pixels(frame_pixels_left());
        drain();
    endtask

    // 1x1 after reset: every pixel is a full frame
    task automatic test_reset_state();
        set_idling(0, 0);
        send_pixel(8'h00);
        send_pixel(8'hFF);
        send_pixel(8'hA5);
        send_pixel(8'h5A);
        drain();
    endtask

    task automatic test_exact_fraction();
        set_idling(56, 0);
        set_geometry(4, 2, 2, 2, 2 << FRAC_BITS, STEP_ONE);
        send_pixels(8);
        drain();
    endtask

    // zero sizes, masked high bits, oversize, sub-unit steps, unused index
    task automatic test_clamped_registers();
        set_idling(0, 56);
        set_geometry(0, 29'h1FFF_E002, 0, 8191, 0, 65535);
        write_reg(CFG_UNUSED_INDEX, POS_MAX);
        send_pixels(3);
        drain();
    endtask

    task automatic test_output_larger();
        set_idling(31, 31);
        finish_frame();
        set_geometry(2, 2, 3, 3, STEP_ONE, STEP_ONE);
        send_pixels(4);
        drain();
    endtask

    task automatic test_position_overflow();
        set_idling(0, 0);
        finish_frame();
        set_geometry(4, 1, 3, 1, POS_MAX, 29'h1000_0000);
        send_pixels(4);
        drain();
    endtask

    // counters already past the new sizes end the row and frame at once
    task automatic test_mid_frame_change();
        set_idling(56, 0);
        set_geometry(4, 4, 2, 2, 2 << FRAC_BITS, 2 << FRAC_BITS);
        send_pixels(5);
        drain();
        write_reg(CFG_SOURCE_COLUMNS, 1);
        write_reg(CFG_SOURCE_ROWS, 2);
        send_pixels(3);
        drain();
    endtask

    // one long row, every third column picked
    task automatic test_long_row();
        set_idling(0, 0);
        finish_frame();
        set_geometry(300, 1, 100, 1, 3 << FRAC_BITS, STEP_ONE);
        send_pixels(300);
        drain();
    endtask

    function automatic logic [CFG_DATA_BITS-1:0] noisy_size();
        logic [CFG_DATA_BITS-1:0] v;
        v = CFG_DATA_BITS'($urandom());
        v[SIZE_BITS-1:0] = SIZE_BITS'($urandom_range(15));
        return v;
    endfunction

    function automatic logic [CFG_DATA_BITS-1:0] noisy_step();
        if ($urandom_range(3) == 0)
            return CFG_DATA_BITS'($urandom());
        return CFG_DATA_BITS'($urandom_range(20 << FRAC_BITS));
    endfunction

    task automatic test_random_frames();
        int sent;
        int phase;
        int sc;
        int sr;
        int oc;
        int orows;
        int frame_count;
        sent  = 0;
        phase = 0;
        while (sent < RANDOM_ITEMS)
        begin
            case (phase % 4)
                0: set_idling(0, 0);
                1: set_idling(56, 0);
                2: set_idling(0, 56);
                default: set_idling(31, 31);
            endcase
            if ($urandom_range(4) == 0)
            begin
                // registers rewritten in the middle of whatever frame is running
                if ($urandom_range(1)) write_reg(CFG_SOURCE_COLUMNS, noisy_size());
                if ($urandom_range(1)) write_reg(CFG_SOURCE_ROWS, noisy_size());
                if ($urandom_range(1)) write_reg(CFG_OUTPUT_COLUMNS, noisy_size());
                if ($urandom_range(1)) write_reg(CFG_OUTPUT_ROWS, noisy_size());
                if ($urandom_range(1)) write_reg(CFG_COLUMN_STEP, noisy_step());
                if ($urandom_range(1)) write_reg(CFG_ROW_STEP, noisy_step());
                frame_count = $urandom_range(1, 40);
                send_pixels(frame_count);
                sent += frame_count;
                drain();
            end
            else
            begin
                sent += frame_pixels_left();
                finish_frame();
                sc    = ($urandom_range(3) == 0) ? $urandom_range(17, 80)
                                                 : $urandom_range(1, 16);
                sr    = $urandom_range(1, 8);
                oc    = $urandom_range(1, sc);
                orows = $urandom_range(1, sr);
                set_geometry(CFG_DATA_BITS'(sc), CFG_DATA_BITS'(sr),
                             CFG_DATA_BITS'(oc), CFG_DATA_BITS'(orows),
                             CFG_DATA_BITS'((sc << FRAC_BITS) / oc),
                             CFG_DATA_BITS'((sr << FRAC_BITS) / orows));
                frame_count = (sc > 16) ? 1 : $urandom_range(1, 3);
                send_pixels(frame_count * sc * sr);
                sent += frame_count * sc * sr;
                drain();
            end
            phase++;
        end
    endtask

    initial
    begin
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        test_reset_state();
        test_exact_fraction();
        test_clamped_registers();
        test_output_larger();
        test_position_overflow();
        test_mid_frame_change();
        test_long_row();
        test_random_frames();
        if (fail_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

    initial
    begin
        #2_000_000;
        $display("*** FAILED ***");
        $finish;
    end

endmodule
